>>> sv/cafe_pkg.sv
// Package: mode codes, flag bit positions and stack access codes for the execute unit.
`default_nettype none
package cafe_pkg;
	localparam logic [6:0] M_ADC = 7'd0, M_AND = 7'd1, M_ASLM = 7'd2, M_ASLA = 7'd3,
		M_BCC = 7'd4, M_BCS = 7'd5, M_BEQ = 7'd6, M_BIT = 7'd7, M_BMI = 7'd8,
		M_BNE = 7'd9, M_BPL = 7'd10, M_BVC = 7'd11, M_BVS = 7'd12, M_CLC = 7'd13,
		M_CLD = 7'd14, M_CLI = 7'd15, M_CLV = 7'd16, M_CMP = 7'd17, M_CPX = 7'd18,
		M_CPY = 7'd19, M_DEC = 7'd20, M_DEX = 7'd21, M_DEY = 7'd22, M_EOR = 7'd23,
		M_INC = 7'd24, M_INX = 7'd25, M_INY = 7'd26, M_LDA = 7'd27, M_LDX = 7'd28,
		M_LDY = 7'd29, M_LSRM = 7'd30, M_LSRA = 7'd31, M_NOP = 7'd32, M_ORA = 7'd33,
		M_PHA = 7'd34, M_PHP = 7'd35, M_PLA = 7'd36, M_PLP = 7'd37, M_ROLM = 7'd38,
		M_ROLA = 7'd39, M_RORM = 7'd40, M_RORA = 7'd41, M_SBC = 7'd42, M_SEC = 7'd43,
		M_SED = 7'd44, M_SEI = 7'd45, M_STA = 7'd46, M_STX = 7'd47, M_STY = 7'd48,
		M_TAX = 7'd49, M_TAY = 7'd50, M_TSX = 7'd51, M_TXA = 7'd52, M_TXS = 7'd53,
		M_TYA = 7'd54, M_ALR = 7'd55, M_ANC = 7'd56, M_ANE = 7'd57, M_ARR = 7'd58,
		M_DCP = 7'd59, M_ISC = 7'd60, M_LAS = 7'd61, M_LAX = 7'd62, M_LXA = 7'd63,
		M_RLA = 7'd64, M_RRA = 7'd65, M_SAX = 7'd66, M_SBX = 7'd67, M_SHA = 7'd68,
		M_SHX = 7'd69, M_SHY = 7'd70, M_SLO = 7'd71, M_SRE = 7'd72, M_TAS = 7'd73;

	localparam int F_C = 0, F_Z = 1, F_I = 2, F_D = 3, F_B = 4, F_ONE = 5, F_V = 6, F_N = 7;

	localparam logic [1:0] SA_NONE = 2'd0, SA_PUSH = 2'd1, SA_PULL = 2'd2;
	localparam logic [7:0] SP_RESET = 8'hFD;
	localparam logic [7:0] P_RESET = 8'b0010_0000;
	localparam logic [7:0] LXA_MAGIC = 8'hEE;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] sp;
		logic [7:0] p;
	} regs_t;

	typedef struct packed {
		logic       write_enable;
		logic [7:0] write_data;
		logic [1:0] stack_access;
		logic [7:0] stack_slot;
		logic       branch_taken;
		regs_t      regs;
	} result_t;

	// Packed from the top down, so mode sits in the lowest bits.
	typedef struct packed {
		logic [7:0] address_high;
		logic [7:0] operand;
		logic [6:0] mode;
	} item_t;
endpackage
`default_nettype wire

>>> sv/cafe_alu.sv
// Combinational execute logic: one decoded operation applied to the register file.
`default_nettype none
module cafe_alu import cafe_pkg::*; (
	input  item_t   item,
	input  regs_t   cur,
	output result_t res
);
	logic [7:0] v, hp1, m, sh_in, sh_out, add_in, nz_val, cmp_r, cmp_v;
	logic [8:0] sum, diff;
	logic       sh_c, do_nz, do_add, do_cmp;
	logic [1:0] sh_kind;
	regs_t      r;

	assign v   = item.operand;
	assign hp1 = item.address_high + 8'd1;

	always_comb begin
		r        = cur;
		res      = '0;
		m        = 8'd0;
		sh_in    = v;
		sh_kind  = 2'd0;
		add_in   = v;
		do_add   = 1'b0;
		do_cmp   = 1'b0;
		cmp_r    = cur.a;
		cmp_v    = v;
		do_nz    = 1'b0;
		nz_val   = 8'd0;
		// Shift operand select and shared shift/rotate unit
		unique case (item.mode)
			M_ASLA, M_LSRA, M_ROLA, M_RORA: sh_in = cur.a;
			M_ALR, M_ARR: sh_in = cur.a & v;
			default: sh_in = v;
		endcase
		unique case (item.mode)
			M_ASLM, M_ASLA, M_SLO: sh_kind = 2'd0;
			M_LSRM, M_LSRA, M_ALR, M_SRE: sh_kind = 2'd1;
			M_ROLM, M_ROLA, M_RLA: sh_kind = 2'd2;
			default: sh_kind = 2'd3;
		endcase
		unique case (sh_kind)
			2'd0: begin sh_out = {sh_in[6:0], 1'b0}; sh_c = sh_in[7]; end
			2'd1: begin sh_out = {1'b0, sh_in[7:1]}; sh_c = sh_in[0]; end
			2'd2: begin sh_out = {sh_in[6:0], cur.p[F_C]}; sh_c = sh_in[7]; end
			default: begin sh_out = {cur.p[F_C], sh_in[7:1]}; sh_c = sh_in[0]; end
		endcase

		unique case (item.mode)
			M_ADC: do_add = 1'b1;
			M_SBC: begin add_in = ~v; do_add = 1'b1; end
			M_AND: begin r.a = cur.a & v; nz_val = r.a; do_nz = 1'b1; end
			M_EOR: begin r.a = cur.a ^ v; nz_val = r.a; do_nz = 1'b1; end
			M_ORA: begin r.a = cur.a | v; nz_val = r.a; do_nz = 1'b1; end
			M_ASLM, M_LSRM, M_ROLM, M_RORM: begin
				res.write_data = sh_out; res.write_enable = 1'b1;
				r.p[F_C] = sh_c; nz_val = sh_out; do_nz = 1'b1;
			end
			M_ASLA, M_LSRA, M_ROLA, M_RORA, M_ALR: begin
				r.a = sh_out; r.p[F_C] = sh_c; nz_val = sh_out; do_nz = 1'b1;
			end
			M_BCC: res.branch_taken = ~cur.p[F_C];
			M_BCS: res.branch_taken = cur.p[F_C];
			M_BEQ: res.branch_taken = cur.p[F_Z];
			M_BNE: res.branch_taken = ~cur.p[F_Z];
			M_BMI: res.branch_taken = cur.p[F_N];
			M_BPL: res.branch_taken = ~cur.p[F_N];
			M_BVS: res.branch_taken = cur.p[F_V];
			M_BVC: res.branch_taken = ~cur.p[F_V];
			M_BIT: begin
				r.p[F_N] = v[7]; r.p[F_V] = v[6]; r.p[F_Z] = ((v & cur.a) == 8'd0);
			end
			M_CLC: r.p[F_C] = 1'b0;
			M_CLD: r.p[F_D] = 1'b0;
			M_CLI: r.p[F_I] = 1'b0;
			M_CLV: r.p[F_V] = 1'b0;
			M_SEC: r.p[F_C] = 1'b1;
			M_SED: r.p[F_D] = 1'b1;
			M_SEI: r.p[F_I] = 1'b1;
			M_CMP: do_cmp = 1'b1;
			M_CPX: begin cmp_r = cur.x; do_cmp = 1'b1; end
			M_CPY: begin cmp_r = cur.y; do_cmp = 1'b1; end
			M_DEC: begin
				m = v - 8'd1; res.write_data = m; res.write_enable = 1'b1;
				nz_val = m; do_nz = 1'b1;
			end
			M_INC: begin
				m = v + 8'd1; res.write_data = m; res.write_enable = 1'b1;
				nz_val = m; do_nz = 1'b1;
			end
			M_DEX: begin r.x = cur.x - 8'd1; nz_val = r.x; do_nz = 1'b1; end
			M_DEY: begin r.y = cur.y - 8'd1; nz_val = r.y; do_nz = 1'b1; end
			M_INX: begin r.x = cur.x + 8'd1; nz_val = r.x; do_nz = 1'b1; end
			M_INY: begin r.y = cur.y + 8'd1; nz_val = r.y; do_nz = 1'b1; end
			M_LDA, M_PLA: begin r.a = v; nz_val = v; do_nz = 1'b1; end
			M_LDX: begin r.x = v; nz_val = v; do_nz = 1'b1; end
			M_LDY: begin r.y = v; nz_val = v; do_nz = 1'b1; end
			M_LAX: begin r.a = v; r.x = v; nz_val = v; do_nz = 1'b1; end
			M_STA: begin res.write_data = cur.a; res.write_enable = 1'b1; end
			M_STX: begin res.write_data = cur.x; res.write_enable = 1'b1; end
			M_STY: begin res.write_data = cur.y; res.write_enable = 1'b1; end
			M_SAX: begin res.write_data = cur.a & cur.x; res.write_enable = 1'b1; end
			M_TAX: begin r.x = cur.a; nz_val = cur.a; do_nz = 1'b1; end
			M_TAY: begin r.y = cur.a; nz_val = cur.a; do_nz = 1'b1; end
			M_TSX: begin r.x = cur.sp; nz_val = cur.sp; do_nz = 1'b1; end
			M_TXA: begin r.a = cur.x; nz_val = cur.x; do_nz = 1'b1; end
			M_TYA: begin r.a = cur.y; nz_val = cur.y; do_nz = 1'b1; end
			M_TXS: r.sp = cur.x;
			M_PHA, M_PHP: begin
				res.write_data = (item.mode == M_PHA) ? cur.a
					: (cur.p | 8'b0011_0000);
				res.stack_access = SA_PUSH;
				res.stack_slot = cur.sp;
				r.sp = cur.sp - 8'd1;
			end
			M_PLP: r.p = (v | 8'b0010_0000) & 8'b1110_1111;
			M_ANC: begin
				r.a = cur.a & v; nz_val = r.a; do_nz = 1'b1; r.p[F_C] = r.a[7];
			end
			M_ANE: begin r.a = cur.x & v; nz_val = r.a; do_nz = 1'b1; end
			M_ARR: begin
				r.a = sh_out; nz_val = sh_out; do_nz = 1'b1;
				r.p[F_C] = sh_out[6]; r.p[F_V] = sh_out[6] ^ sh_out[5];
			end
			M_DCP: begin
				m = v - 8'd1; res.write_data = m; res.write_enable = 1'b1;
				cmp_v = m; do_cmp = 1'b1;
			end
			M_ISC: begin
				m = v + 8'd1; res.write_data = m; res.write_enable = 1'b1;
				add_in = ~m; do_add = 1'b1;
			end
			M_LAS: begin
				m = cur.sp & v; r.sp = m; r.a = m; r.x = m; nz_val = m; do_nz = 1'b1;
			end
			M_LXA: begin
				m = (cur.a | LXA_MAGIC) & v; r.a = m; r.x = m; nz_val = m; do_nz = 1'b1;
			end
			M_RLA: begin
				res.write_data = sh_out; res.write_enable = 1'b1; r.p[F_C] = sh_c;
				r.a = cur.a & sh_out; nz_val = r.a; do_nz = 1'b1;
			end
			M_SLO: begin
				res.write_data = sh_out; res.write_enable = 1'b1; r.p[F_C] = sh_c;
				r.a = cur.a | sh_out; nz_val = r.a; do_nz = 1'b1;
			end
			M_SRE: begin
				res.write_data = sh_out; res.write_enable = 1'b1; r.p[F_C] = sh_c;
				r.a = cur.a ^ sh_out; nz_val = r.a; do_nz = 1'b1;
			end
			M_RRA: begin
				res.write_data = sh_out; res.write_enable = 1'b1; r.p[F_C] = sh_c;
				add_in = sh_out; do_add = 1'b1;
			end
			M_SBX: begin cmp_r = cur.a & cur.x; do_cmp = 1'b1; end
			M_SHA: begin
				res.write_data = cur.a & cur.x & hp1; res.write_enable = 1'b1;
			end
			M_SHX: begin res.write_data = cur.x & hp1; res.write_enable = 1'b1; end
			M_SHY: begin res.write_data = cur.y & hp1; res.write_enable = 1'b1; end
			M_TAS: begin
				r.sp = cur.a & cur.x;
				res.write_data = cur.a & cur.x & hp1; res.write_enable = 1'b1;
			end
			default: ;
		endcase

		if (item.mode == M_PLA || item.mode == M_PLP) begin
			res.stack_access = SA_PULL;
			r.sp = cur.sp + 8'd1;
			res.stack_slot = r.sp;
		end

		// Binary adder; carry in is the carry flag, which for RRA is the one its rotate just set
		sum = {1'b0, cur.a} + {1'b0, add_in} + {8'd0, r.p[F_C]};
		if (do_add) begin
			r.a = sum[7:0];
			r.p[F_C] = sum[8];
			r.p[F_V] = ~(cur.a[7] ^ add_in[7]) & (cur.a[7] ^ sum[7]);
			nz_val = sum[7:0]; do_nz = 1'b1;
		end

		diff = {1'b0, cmp_r} - {1'b0, cmp_v};
		if (do_cmp) begin
			r.p[F_C] = ~diff[8];
			nz_val = diff[7:0]; do_nz = 1'b1;
			if (item.mode == M_SBX) r.x = diff[7:0];
		end

		if (do_nz) begin
			r.p[F_Z] = (nz_val == 8'd0);
			r.p[F_N] = nz_val[7];
		end
		res.regs = r;
	end
endmodule
`default_nettype wire

>>> sv/cpu_alu_flag_execute_unit.sv
// Top level: input register, architectural registers, execute logic and result register.
//
//  channel | dir | handshake               | payload
//  s_axis  | in  | s_axis_tvalid/tready    | tdata: mode[6:0], operand[14:7], address_high[22:15]
//  m_axis  | out | m_axis_tvalid/tready    | tdata: write_enable, write_data, stack_access,
//          |     |                         |   stack_slot, branch_taken, acc, x, y, sp, flags
//
// One transaction per cycle sustained while m_axis_tready stays high; two register stages
// (input, result), so a result shows on m_axis after passing the input and result registers.
// The register file updates as the item leaves the input register, so the next item
// sees it without bubbles. Reset (arst_n low) empties both stages and loads A=X=Y=0,
// SP=0xFD, P=0x20. A stalled output holds its result; the input stage takes one more
// transaction and then drops tready until the result stage drains.
`default_nettype none
module cpu_alu_flag_execute_unit import cafe_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // mode[6:0], operand[14:7], address_high[22:15]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata    // write_enable[0], write_data[8:1],
	                                         // stack_access[10:9], stack_slot[18:11],
	                                         // branch_taken[19], acc_out[27:20], x_out[35:28],
	                                         // y_out[43:36], sp_out[51:44], flags_out[59:52]
);
	item_t   item_s1;
	logic    vld_s1, vld_s2;
	regs_t   regs_q;
	result_t res_c, res_s2;
	logic    adv_s2, adv_s1;

	assign adv_s2 = ~vld_s2 | m_axis_tready;
	assign adv_s1 = ~vld_s1 | adv_s2;
	assign s_axis_tready = adv_s1;

	cafe_alu u_alu (.item(item_s1), .cur(regs_q), .res(res_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			regs_q <= '{a: 8'd0, x: 8'd0, y: 8'd0, sp: SP_RESET, p: P_RESET};
		end else begin
			if (adv_s1) vld_s1 <= s_axis_tvalid;
			if (adv_s2) vld_s2 <= vld_s1;
			// commit the architectural state as the item moves to the result stage
			if (adv_s2 && vld_s1) regs_q <= res_c.regs;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_axis_tvalid) item_s1 <= s_axis_tdata[22:0];
		if (adv_s2 && vld_s1) res_s2 <= res_c;
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata = {4'd0, res_s2.regs.p, res_s2.regs.sp, res_s2.regs.y,
		res_s2.regs.x, res_s2.regs.a, res_s2.branch_taken, res_s2.stack_slot,
		res_s2.stack_access, res_s2.write_data, res_s2.write_enable};
endmodule
`default_nettype wire

>>> sv/cafe_checker.sv
// Port-level checker for the execute unit, bound to the top level.
`default_nettype none
module cafe_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [63:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");
	a_stack_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[10:9] != 2'd3)
		else $error("bad stack access code");
	a_const_bit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[57])
		else $error("flag bit five clear");
	a_no_both: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[10:9] != 2'd0))
		else $error("memory write together with stack access");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");
endmodule

bind cpu_alu_flag_execute_unit cafe_checker u_cafe_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
